[sv/sktul_pkg.sv]
`timescale 1ns / 1ps

package sktul_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_UPSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FULL     = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FOUND    = 3'd4,
        ST_MISS     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CMP   = 2'd1,
        S_APPLY = 2'd2
    } fsm_state_t;

    // Commands broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rep_en;
    } skt_cmd_t;

endpackage

[sv/sktul_cell.sv]
`timescale 1ns / 1ps

module sktul_cell
    import sktul_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  skt_cmd_t         cmd,
    input  logic [CNT_W-1:0] count,
    input  logic [KEY_W-1:0] probe_key,
    input  logic [VAL_W-1:0] new_rev,
    input  logic [VAL_W-1:0] new_gen,
    input  logic             left_gt,
    input  logic [KEY_W-1:0] left_key,
    input  logic [VAL_W-1:0] left_rev,
    input  logic [VAL_W-1:0] left_gen,
    output logic [KEY_W-1:0] key_q,
    output logic [VAL_W-1:0] rev_q,
    output logic [VAL_W-1:0] gen_q,
    output logic             gt_q,
    output logic             eq_q
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] rev_reg;
    logic [VAL_W-1:0] gen_reg;
    logic             gt_reg;
    logic             eq_reg;
    logic             occupied;

    assign occupied = count > CNT_W'(INDEX);

    always_ff @(posedge aclk) begin
        if (cmd.cmp_en) begin
            gt_reg <= occupied && (key_reg > probe_key);
            eq_reg <= occupied && (key_reg == probe_key);
        end
        // Records at or after the insert point move one cell to the right;
        // the cell right after the last greater key takes the new record.
        if (cmd.ins_en && !gt_reg) begin
            if (left_gt) begin
                key_reg <= probe_key;
                rev_reg <= new_rev;
                gen_reg <= new_gen;
            end else begin
                key_reg <= left_key;
                rev_reg <= left_rev;
                gen_reg <= left_gen;
            end
        end else if (cmd.rep_en && eq_reg) begin
            rev_reg <= new_rev;
            gen_reg <= new_gen;
        end
    end

    assign key_q = key_reg;
    assign rev_q = rev_reg;
    assign gen_q = gen_reg;
    assign gt_q  = gt_reg;
    assign eq_q  = eq_reg;

endmodule

[sv/sktul_chain.sv]
`timescale 1ns / 1ps

module sktul_chain
    import sktul_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int CNT_W = 7
) (
    input  logic                   aclk,
    input  skt_cmd_t               cmd,
    input  logic [CNT_W-1:0]       count,
    input  logic [KEY_W-1:0]       probe_key,
    input  logic [VAL_W-1:0]       new_rev,
    input  logic [VAL_W-1:0]       new_gen,
    output logic                   hit,
    output logic [VAL_W-1:0]       found_rev,
    output logic [VAL_W-1:0]       found_gen,
    output logic [TABLE_DEPTH-1:0] eq_vec
);

    logic [KEY_W-1:0] key_w [TABLE_DEPTH];
    logic [VAL_W-1:0] rev_w [TABLE_DEPTH];
    logic [VAL_W-1:0] gen_w [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] gt_vec;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                sktul_cell #(.INDEX(gi), .CNT_W(CNT_W)) u_cell (
                    .aclk     (aclk),
                    .cmd      (cmd),
                    .count    (count),
                    .probe_key(probe_key),
                    .new_rev  (new_rev),
                    .new_gen  (new_gen),
                    .left_gt  (1'b1),
                    .left_key (probe_key),
                    .left_rev (new_rev),
                    .left_gen (new_gen),
                    .key_q    (key_w[gi]),
                    .rev_q    (rev_w[gi]),
                    .gen_q    (gen_w[gi]),
                    .gt_q     (gt_vec[gi]),
                    .eq_q     (eq_vec[gi])
                );
            end else begin : g_body
                sktul_cell #(.INDEX(gi), .CNT_W(CNT_W)) u_cell (
                    .aclk     (aclk),
                    .cmd      (cmd),
                    .count    (count),
                    .probe_key(probe_key),
                    .new_rev  (new_rev),
                    .new_gen  (new_gen),
                    .left_gt  (gt_vec[gi-1]),
                    .left_key (key_w[gi-1]),
                    .left_rev (rev_w[gi-1]),
                    .left_gen (gen_w[gi-1]),
                    .key_q    (key_w[gi]),
                    .rev_q    (rev_w[gi]),
                    .gen_q    (gen_w[gi]),
                    .gt_q     (gt_vec[gi]),
                    .eq_q     (eq_vec[gi])
                );
            end
        end
    endgenerate

    // Keys are unique, so at most one match flag is set and a masked OR
    // selects its record.
    always_comb begin
        found_rev = '0;
        found_gen = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            found_rev = found_rev | (rev_w[i] & {VAL_W{eq_vec[i]}});
            found_gen = found_gen | (gen_w[i] & {VAL_W{eq_vec[i]}});
        end
    end

    assign hit = |eq_vec;

endmodule

[sv/sorted_key_table_upsert_lookup_unit.sv]
`timescale 1ns / 1ps
// Each item goes through a compare step, in which every cell compares its key, and then an
// apply step, in which the row shifts, overwrites or reads out and the result is registered;
// the apply step waits while the output is stalled, and the next item is taken during it.
// Reset: aresetn (synchronous, active low) empties the table, drops a pending result and
// holds s_tready low; the record cells themselves are not cleared.
module sorted_key_table_upsert_lookup_unit
    import sktul_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_W = 1 + 2 * VAL_W + CNT_W,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // day_key[31:0], revision[63:32], generation_in[95:64]
    input  logic [95:0]          s_tdata,
    // mode[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // is_ready[0], stored_revision[32:1], stored_generation[64:33], entries_held above
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]           m_tuser
);

    fsm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] rev_reg;
    logic [VAL_W-1:0] gen_reg;

    logic             m_tvalid_reg, m_tvalid_next;
    status_t          status_reg, status_next;
    logic             ready_reg, ready_next;
    logic [VAL_W-1:0] srev_reg, srev_next;
    logic [VAL_W-1:0] sgen_reg, sgen_next;
    logic [CNT_W-1:0] held_reg;

    skt_cmd_t               cmd;
    logic                   hit;
    logic [VAL_W-1:0]       found_rev;
    logic [VAL_W-1:0]       found_gen;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic                   out_free;
    logic                   s_fire;
    logic                   out_load;
    logic                   full;

    sktul_chain #(.TABLE_DEPTH(TABLE_DEPTH), .CNT_W(CNT_W)) u_chain (
        .aclk     (aclk),
        .cmd      (cmd),
        .count    (count_reg),
        .probe_key(key_reg),
        .new_rev  (rev_reg),
        .new_gen  (gen_reg),
        .hit      (hit),
        .found_rev(found_rev),
        .found_gen(found_gen),
        .eq_vec   (eq_vec)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign full     = count_reg == CNT_W'(TABLE_DEPTH);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        status_next   = ST_MISS;
        ready_next    = 1'b0;
        srev_next     = '0;
        sgen_next     = '0;
        case (state_reg)
            S_IDLE: begin
                // No transfer is taken while the block is held in reset.
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp_en = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    s_tready = 1'b1;
                    state_next = s_tvalid ? S_CMP : S_IDLE;
                    case (mode_reg)
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_UPSERT: begin
                            if (key_reg == '0) begin
                                status_next = ST_INVALID;
                            end else if (hit) begin
                                cmd.rep_en  = 1'b1;
                                status_next = ST_REPLACED;
                            end else if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                cmd.ins_en  = 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = ST_INSERTED;
                            end
                        end
                        MODE_QUERY: begin
                            if (key_reg == '0) begin
                                status_next = ST_INVALID;
                            end else if (hit) begin
                                status_next = ST_FOUND;
                                srev_next   = found_rev;
                                sgen_next   = found_gen;
                                ready_next  = found_rev == rev_reg;
                            end
                        end
                        default: begin
                            status_next = ST_MISS;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            rev_reg  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            gen_reg  <= s_tdata[KEY_W+2*VAL_W-1:KEY_W+VAL_W];
        end
        if (out_load) begin
            status_reg <= status_next;
            ready_reg  <= ready_next;
            srev_reg   <= srev_next;
            sgen_reg   <= sgen_next;
            held_reg   <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({held_reg, sgen_reg, srev_reg, ready_reg});
    assign m_tuser  = status_reg;

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(eq_vec))
        else $error("more than one cell matched the probe key");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count exceeds table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table by one record");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result raised outside the apply step");

endmodule

[sim/tb_sorted_key_table_upsert_lookup_unit.sv]
`timescale 1ns / 1ps

module tb_sorted_key_table_upsert_lookup_unit;
    import sktul_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic        ready;
        logic [31:0] srev;
        logic [31:0] sgen;
        logic [6:0]  held;
    } table_result_t;

    typedef struct packed {
        logic [1:0]    mode;
        logic [31:0]   key;
        logic [31:0]   rev;
        logic [31:0]   gen;
        logic          has_exp;
        table_result_t res;
    } dir_row_t;

    localparam table_result_t NO_RES = '{ST_INSERTED, 1'b0, 32'd0, 32'd0, 7'd0};
    localparam int DIR_ROWS = 18;

    // Rows with has_exp set carry the outcome written out by hand; the rest go
    // through the table predictor.
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{MODE_QUERY,  32'd5, 32'd0, 32'd0, 1'b1,
          '{ST_MISS, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{MODE_UPSERT, 32'd0, 32'h0000_1234, 32'h0000_5678, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{MODE_QUERY,  32'd0, 32'd0, 32'd0, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{MODE_UPSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ST_INSERTED, 1'b0, 32'd0, 32'd0, 7'd1}},
        '{MODE_UPSERT, 32'd1, 32'd0, 32'd0, 1'b1,
          '{ST_INSERTED, 1'b0, 32'd0, 32'd0, 7'd2}},
        '{MODE_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1,
          '{ST_FOUND, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd2}},
        '{MODE_QUERY,  32'd1, 32'd1, 32'd0, 1'b1,
          '{ST_FOUND, 1'b0, 32'd0, 32'd0, 7'd2}},
        '{MODE_UPSERT, 32'd1, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1,
          '{ST_REPLACED, 1'b0, 32'd0, 32'd0, 7'd2}},
        '{MODE_QUERY,  32'd1, 32'hAAAA_5555, 32'd0, 1'b0, NO_RES},
        '{MODE_UPSERT, 32'h8000_0000, 32'd1, 32'd2, 1'b0, NO_RES},
        '{MODE_UPSERT, 32'h7FFF_FFFF, 32'd3, 32'd4, 1'b0, NO_RES},
        '{MODE_QUERY,  32'h7FFF_FFFE, 32'd3, 32'd0, 1'b0, NO_RES},
        '{MODE_QUERY,  32'h8000_0000, 32'd0, 32'd0, 1'b0, NO_RES},
        '{MODE_UNUSED, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{MODE_QUERY,  32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_RES},
        '{MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ST_MISS, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{MODE_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1,
          '{ST_MISS, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{MODE_UPSERT, 32'd1, 32'd7, 32'd9, 1'b1,
          '{ST_INSERTED, 1'b0, 32'd0, 32'd0, 7'd1}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // day_key[31:0], revision[63:32], generation_in[95:64]
    logic [95:0] s_tdata;
    // mode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // is_ready[0], stored_revision[32:1], stored_generation[64:33], entries_held[71:65]
    logic [71:0] m_tdata;
    // status[2:0]
    logic [2:0]  m_tuser;

    // Shadow copy of the record table, kept in descending key order.
    logic [31:0] key_tbl [DEPTH];
    logic [31:0] rev_tbl [DEPTH];
    logic [31:0] gen_tbl [DEPTH];
    int          held_cnt;

    table_result_t pending_results [$];
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            failed;

    sorted_key_table_upsert_lookup_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic table_result_t predict_table_step(input logic [1:0] mode,
                                                         input logic [31:0] key,
                                                         input logic [31:0] rev,
                                                         input logic [31:0] gen);
        table_result_t r;
        int            pos;
        bit            hit;
        r.status = ST_MISS;
        r.ready  = 1'b0;
        r.srev   = '0;
        r.sgen   = '0;
        pos = 0;
        while (pos < held_cnt && key_tbl[pos] > key) pos++;
        hit = (pos < held_cnt) && (key_tbl[pos] == key);
        if (mode == MODE_CLEAR) begin
            held_cnt = 0;
        end else if (mode == MODE_UPSERT) begin
            if (key == '0) begin
                r.status = ST_INVALID;
            end else if (hit) begin
                rev_tbl[pos] = rev;
                gen_tbl[pos] = gen;
                r.status = ST_REPLACED;
            end else if (held_cnt >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int j = held_cnt; j > pos; j--) begin
                    key_tbl[j] = key_tbl[j-1];
                    rev_tbl[j] = rev_tbl[j-1];
                    gen_tbl[j] = gen_tbl[j-1];
                end
                key_tbl[pos] = key;
                rev_tbl[pos] = rev;
                gen_tbl[pos] = gen;
                held_cnt++;
                r.status = ST_INSERTED;
            end
        end else if (mode == MODE_QUERY) begin
            if (key == '0) begin
                r.status = ST_INVALID;
            end else if (hit) begin
                r.status = ST_FOUND;
                r.srev   = rev_tbl[pos];
                r.sgen   = gen_tbl[pos];
                r.ready  = (rev_tbl[pos] == rev);
            end
        end
        r.held = held_cnt[6:0];
        return r;
    endfunction

    // Entered and left at a falling edge; the prediction is taken at the
    // rising edge where the transfer happens.
    task automatic send_item(input logic [1:0] mode, input logic [31:0] key,
                             input logic [31:0] rev, input logic [31:0] gen,
                             input logic has_exp, input table_result_t exp_res);
        table_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {gen, rev, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_table_step(mode, key, rev, gen);
        pending_results.push_back(has_exp ? exp_res : r);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] rev;
        int          sel;
        int          idx;
        for (int n = 0; n < count; n++) begin
            // Clears are rare so that the table fills up and stays full for a while.
            sel = $urandom_range(999);
            if (sel < 4)
                mode = MODE_CLEAR;
            else if (sel < 10)
                mode = MODE_UNUSED;
            else if (sel < 560)
                mode = MODE_UPSERT;
            else
                mode = MODE_QUERY;
            rev = $urandom;
            sel = $urandom_range(99);
            if (sel < 45 && held_cnt > 0) begin
                idx = $urandom_range(held_cnt - 1);
                key = key_tbl[idx];
                if (mode == MODE_QUERY && $urandom_range(1) == 1)
                    rev = rev_tbl[idx];
            end else if (sel < 75) begin
                key = $urandom_range(1, 300);
            end else if (sel < 80) begin
                key = '0;
            end else if (sel < 86) begin
                case ($urandom_range(3))
                    0: key = 32'd1;
                    1: key = 32'hFFFF_FFFF;
                    2: key = 32'hFFFF_FFFE;
                    default: key = 32'h8000_0000;
                endcase
            end else begin
                key = $urandom;
            end
            send_item(mode, key, rev, $urandom, 1'b0, NO_RES);
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected: status %0d data %h",
                         $time, m_tuser, m_tdata);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[0] !== want.ready) begin
                    $display("%0t: is_ready expected %0d actual %0d",
                             $time, want.ready, m_tdata[0]);
                    failed = 1'b1;
                end
                if (m_tdata[32:1] !== want.srev) begin
                    $display("%0t: stored_revision expected %h actual %h",
                             $time, want.srev, m_tdata[32:1]);
                    failed = 1'b1;
                end
                if (m_tdata[64:33] !== want.sgen) begin
                    $display("%0t: stored_generation expected %h actual %h",
                             $time, want.sgen, m_tdata[64:33]);
                    failed = 1'b1;
                end
                if (m_tdata[71:65] !== want.held) begin
                    $display("%0t: entries_held expected %0d actual %0d",
                             $time, want.held, m_tdata[71:65]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("FAIL sorted_key_table_upsert_lookup_unit");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        failed   = 1'b0;
        held_cnt = 0;
        send_idle_pct = 6;
        recv_idle_pct = 71;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIR_TABLE[i].mode, DIR_TABLE[i].key, DIR_TABLE[i].rev,
                      DIR_TABLE[i].gen, DIR_TABLE[i].has_exp, DIR_TABLE[i].res);
        end

        send_random(RANDOM_ITEMS / 3);
        send_idle_pct = 71;
        recv_idle_pct = 6;
        send_random(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (!failed)
            $display("PASS sorted_key_table_upsert_lookup_unit");
        else
            $display("FAIL sorted_key_table_upsert_lookup_unit");
        $finish;
    end

endmodule
